[rtl/sha1_stream_hasher_macros.svh]
// ---------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared assertion forms for the hasher RTL.
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// implication checked every clock, off during reset
`define SHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sha1_pkg.sv]
// ---------------------------------------------------------------------------
// SHA-1 package
// Constants, types and round helpers shared across the hasher.
// ---------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_RUN, ST_SUM, ST_EMIT
  } back_state_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

[rtl/sha1_stream_if.sv]
// ---------------------------------------------------------------------------
// SHA-1 stream channel
// Valid/ready channel carrying a request payload.
// ---------------------------------------------------------------------------
interface sha1_in_if;
  logic             valid;
  logic             ready;
  sha1_pkg::in_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha1_out_if;
  logic              valid;
  logic              ready;
  sha1_pkg::out_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/sha1_ram.sv]
// ---------------------------------------------------------------------------
// SHA-1 generic RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module sha1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/sha1_front.sv]
// ---------------------------------------------------------------------------
// SHA-1 front end
// Accepts requests, drops idle ones and queues the rest for the back end.
// ---------------------------------------------------------------------------
module sha1_front (
  input  logic              clk,
  input  logic              rst,
  sha1_in_if.sink           in_ch,
  output logic              q_valid,
  output sha1_pkg::in_req_t q_data,
  input  logic              q_pop
);
  localparam int unsigned AW = $clog2(sha1_pkg::QDEPTH);
  sha1_pkg::in_req_t q [sha1_pkg::QDEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          take;

  assign in_ch.ready = count != (AW+1)'(sha1_pkg::QDEPTH);
  assign take = in_ch.valid && in_ch.ready;
  assign push = take && (in_ch.payload.has_byte || in_ch.payload.end_of_message);
  assign q_valid = count != '0;
  assign q_data = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_ch.payload;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

  `include "sha1_stream_hasher_macros.svh"
  `SHS_ASSERT_IMPL(a_no_pop_empty, clk, rst, q_pop, q_valid)
  `SHS_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= (AW+1)'(sha1_pkg::QDEPTH))
  `SHS_ASSERT_NEXT(a_push_fills, clk, rst, push && !q_pop, count == $past(count) + 1'b1)
endmodule

[rtl/sha1_back.sv]
// ---------------------------------------------------------------------------
// SHA-1 back end
// Fills blocks, pads, runs 80 rounds and emits the digest words.
// ---------------------------------------------------------------------------
module sha1_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sha1_pkg::in_req_t q_data,
  output logic              q_pop,
  sha1_out_if.source        out_ch
);
  sha1_pkg::back_state_t state, state_next;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] win [16];
  logic [6:0]  round;
  logic        final_blk;
  logic        two_blk;
  logic [2:0]  widx;
  logic        out_v;
  logic [31:0] out_w;
  logic [2:0]  out_i;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [31:0] word_acc;

  sha1_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [31:0] w_cur, x_sched, tmp;
  logic        out_free;
  assign out_free = !out_v || out_ch.ready;
  assign x_sched = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_cur = (round < 7'd16) ? ram_rdata : {x_sched[30:0], x_sched[31]};
  assign tmp = {a[26:0], a[31:27]} + sha1_pkg::round_f(round, b, c, d) + e
               + sha1_pkg::round_k(round) + w_cur;
  assign ram_raddr = round[3:0] + ((state == sha1_pkg::ST_RUN) ? 4'd1 : 4'd0);

  logic [31:0] byte_word;
  always_comb begin
    byte_word = word_acc;
    unique case (fill[1:0])
      2'd0: byte_word = {q_data.msg_byte, 24'd0};
      2'd1: byte_word[23:16] = q_data.msg_byte;
      2'd2: byte_word[15:8] = q_data.msg_byte;
      2'd3: byte_word[7:0] = q_data.msg_byte;
      default: byte_word = word_acc;
    endcase
  end
  logic [31:0] pad_word;
  always_comb begin
    pad_word = word_acc;
    unique case (fill[1:0])
      2'd0: pad_word = {sha1_pkg::PAD_BYTE, 24'd0};
      2'd1: pad_word = {word_acc[31:24], sha1_pkg::PAD_BYTE, 16'd0};
      2'd2: pad_word = {word_acc[31:16], sha1_pkg::PAD_BYTE, 8'd0};
      2'd3: pad_word = {word_acc[31:8], sha1_pkg::PAD_BYTE};
      default: pad_word = word_acc;
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = fill[5:2];
    ram_wdata = byte_word;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_data.has_byte) begin
            ram_we = fill[1:0] == 2'd3;
            if (fill == 6'd63) state_next = sha1_pkg::ST_RUN;
            else if (q_data.end_of_message) state_next = sha1_pkg::ST_PAD;
            else q_pop = 1'b1;
          end else begin
            state_next = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        ram_we = 1'b1;
        ram_wdata = final_blk ? 32'd0 : pad_word;
        if (fill[5:2] == 4'd13 && !two_blk) state_next = sha1_pkg::ST_LEN;
        else if (fill[5:2] == 4'd15) state_next = sha1_pkg::ST_RUN;
      end
      sha1_pkg::ST_LEN: begin
        ram_we = 1'b1;
        ram_wdata = fill[2] ? bit_length[31:0] : bit_length[63:32];
        if (fill[5:2] == 4'd15) state_next = sha1_pkg::ST_RUN;
      end
      sha1_pkg::ST_RUN: begin
        if (round == 7'd79) state_next = sha1_pkg::ST_SUM;
      end
      sha1_pkg::ST_SUM: begin
        if (two_blk) state_next = sha1_pkg::ST_PAD;
        else if (final_blk) state_next = sha1_pkg::ST_EMIT;
        else begin
          state_next = sha1_pkg::ST_IDLE;
          q_pop = !q_data.end_of_message;
          if (q_data.end_of_message) state_next = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_EMIT: begin
        if (out_free && widx == 3'd4) begin
          state_next = sha1_pkg::ST_IDLE;
          q_pop = 1'b1;
        end
      end
      default: state_next = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sha1_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bit_length <= '0;
      h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
      h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
      round <= '0;
      final_blk <= 1'b0;
      two_blk <= 1'b0;
      widx <= '0;
      out_v <= 1'b0;
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0;
    end else begin
      out_v <= (state == sha1_pkg::ST_EMIT && out_free) || (out_v && !out_ch.ready);
      unique case (state)
        sha1_pkg::ST_IDLE: begin
          if (q_valid && q_data.has_byte) begin
            fill <= fill + 6'd1;
            bit_length <= bit_length + 64'd8;
            if (fill == 6'd63) begin
              word_acc <= byte_word;
              round <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end else if (q_data.end_of_message) begin
              final_blk <= 1'b0;
              two_blk <= (fill + 6'd1) >= 6'd56;
              word_acc <= (fill[1:0] == 2'd3) ? 32'd0 : byte_word;
            end else begin
              word_acc <= byte_word;
            end
          end else if (q_valid) begin
            final_blk <= 1'b0;
            two_blk <= fill >= 6'd56;
            word_acc <= fill[1:0] == 2'd0 ? 32'd0 : word_acc;
          end
        end
        sha1_pkg::ST_PAD: begin
          final_blk <= 1'b1;
          word_acc <= '0;
          fill <= {fill[5:2] + 4'd1, 2'd0};
          if (fill[5:2] == 4'd15) begin
            round <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        sha1_pkg::ST_LEN: begin
          fill <= {fill[5:2] + 4'd1, 2'd0};
          final_blk <= 1'b1;
          if (fill[5:2] == 4'd15) begin
            round <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        sha1_pkg::ST_RUN: begin
          round <= round + 7'd1;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
        end
        sha1_pkg::ST_SUM: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          fill <= '0;
          if (two_blk) begin
            two_blk <= 1'b0;
            final_blk <= 1'b1;
          end else if (!final_blk) begin
            final_blk <= 1'b0;
            two_blk <= 1'b0;
            word_acc <= {sha1_pkg::PAD_BYTE, 24'd0};
          end
          widx <= '0;
        end
        sha1_pkg::ST_EMIT: begin
          if (out_free) begin
            out_w <= h[widx];
            out_i <= widx;
            widx <= widx + 3'd1;
            if (widx == 3'd4) begin
              h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
              h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
              fill <= '0;
              bit_length <= '0;
              final_blk <= 1'b0;
              two_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == sha1_pkg::ST_RUN) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_cur;
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.payload.digest_word = out_w;
  assign out_ch.payload.word_index = out_i;
  assign out_ch.payload.last_word = out_i == 3'd4;

  `include "sha1_stream_hasher_macros.svh"
  `SHS_ASSERT_IMPL(a_round_range, clk, rst, state == sha1_pkg::ST_RUN, round <= 7'd79)
  `SHS_ASSERT_IMPL(a_emit_index, clk, rst, out_v, out_i <= 3'd4)
  `SHS_ASSERT_NEXT(a_run_advance, clk, rst,
                   state == sha1_pkg::ST_RUN && round != 7'd79, round == $past(round) + 7'd1)
endmodule

[rtl/sha1_stream_hasher.sv]
// ---------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-serial SHA-1 with padding; emits five digest words per message.
// ---------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | msg_byte[7:0], has_byte, end_of_message
//  out_ch   | out | digest_word[31:0], word_index[2:0], last_word
//
//  Each byte is packed into the block buffer; a full block runs 80 rounds,
//  one per cycle, on the shared round unit, and is then folded into the chain.
//  A final item adds up to 16 padding words per block, then five digest words.
//  Reset is synchronous; the front queue accepts while rounds run, until full.
module sha1_stream_hasher (
  input logic     clk,
  input logic     rst,
  sha1_in_if.sink  in_ch,
  sha1_out_if.source out_ch
);
  logic              q_valid;
  logic              q_pop;
  sha1_pkg::in_req_t q_data;

  sha1_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  sha1_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
